FILE: sv/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants for the peer address table: op codes, status
// codes, command kinds and the command beat carried from front to back.
// ----------------------------------------------------------------------------
package pat_pkg;

	// table geometry
	localparam int MAX_PEERS = 8;
	localparam int SLOT_W    = 3;
	localparam int IDX_W     = 4;
	localparam int ADDR_W    = 48;
	localparam int STATE_W   = 2;
	localparam int LQ_W      = 8;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_PEERS - 1);
	localparam logic [LQ_W-1:0]   LQ_CLEAR  = '1;

	// op codes on the input channel
	localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
	localparam logic [OP_W-1:0] OP_DEL   = 3'd1;
	localparam logic [OP_W-1:0] OP_FINDA = 3'd2;
	localparam logic [OP_W-1:0] OP_FINDS = 3'd3;
	localparam logic [OP_W-1:0] OP_ENUM  = 3'd4;
	localparam logic [OP_W-1:0] OP_FLUSH = 3'd5;

	// status codes on the output channel
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

	// classified command kind
	typedef enum logic [2:0] {
		KIND_ADD   = 3'd0,
		KIND_DEL   = 3'd1,
		KIND_FINDA = 3'd2,
		KIND_FINDS = 3'd3,
		KIND_ENUM  = 3'd4,
		KIND_FLUSH = 3'd5,
		KIND_NOP   = 3'd6
	} kind_t;

	// command beat from front to back
	typedef struct packed {
		kind_t               kind;
		logic [ADDR_W-1:0]   addr;
		logic [STATE_W-1:0]  state;
		logic [LQ_W-1:0]     lq;
		logic [IDX_W-1:0]    start;
	} cmd_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

endpackage

FILE: sv/pat_front.sv
// ----------------------------------------------------------------------------
// pat_front
// Input side: takes beats from the input channel, decodes the op code into a
// command kind and pushes the command into the queue.
// ----------------------------------------------------------------------------
module pat_front import pat_pkg::*; (
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     op,
	input  logic [ADDR_W-1:0]   peer_address,
	input  logic [STATE_W-1:0]  assoc_state_in,
	input  logic [LQ_W-1:0]     link_quality_in,
	input  logic [IDX_W-1:0]    start_index,
	input  logic                q_full,
	output logic                q_push,
	output cmd_t                q_cmd
);

	kind_t kind;

	// op decode; unused codes become a no-op
	always_comb begin
		case (op)
			OP_ADD:   kind = KIND_ADD;
			OP_DEL:   kind = KIND_DEL;
			OP_FINDA: kind = KIND_FINDA;
			OP_FINDS: kind = KIND_FINDS;
			OP_ENUM:  kind = KIND_ENUM;
			OP_FLUSH: kind = KIND_FLUSH;
			default:  kind = KIND_NOP;
		endcase
	end

	// handshake and command build
	assign in_stall    = q_full;
	assign q_push      = in_valid & ~q_full;
	assign q_cmd.kind  = kind;
	assign q_cmd.addr  = peer_address;
	assign q_cmd.state = assoc_state_in;
	assign q_cmd.lq    = link_quality_in;
	assign q_cmd.start = start_index;

endmodule

FILE: sv/pat_queue.sv
// ----------------------------------------------------------------------------
// pat_queue
// Two-entry command queue between the front and the back of the table.
// ----------------------------------------------------------------------------
module pat_queue import pat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head_cmd  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/pat_back.sv
// ----------------------------------------------------------------------------
// pat_back
// Table storage and sequencer. Pops a command, walks all slots one per
// cycle to find matches and a free slot (flush and no-op skip the walk),
// then updates the table and loads the output register.
// ----------------------------------------------------------------------------
module pat_back import pat_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_not_empty,
	input  cmd_t                 q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_W-1:0]    hit_slot,
	output logic [ADDR_W-1:0]    hit_address,
	output logic [STATE_W-1:0]   hit_assoc_state,
	output logic [LQ_W-1:0]      hit_link_quality,
	output logic [IDX_W-1:0]     next_index
);

	// table
	logic                valid_q [MAX_PEERS];
	logic [ADDR_W-1:0]   addr_q  [MAX_PEERS];
	logic [STATE_W-1:0]  state_q [MAX_PEERS];
	logic [LQ_W-1:0]     lq_q    [MAX_PEERS];

	// sequencer
	back_state_t         state_fsm_q;
	cmd_t                cmd_q;
	logic [SLOT_W-1:0]   idx_q;
	logic                found_q;
	logic [SLOT_W-1:0]   hit_q;
	logic                free_found_q;
	logic [SLOT_W-1:0]   free_q;
	logic [ADDR_W-1:0]   cap_addr_q;
	logic [STATE_W-1:0]  cap_state_q;
	logic [LQ_W-1:0]     cap_lq_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic [STATE_W-1:0]  res_state_q;
	logic [LQ_W-1:0]     res_lq_q;
	logic [IDX_W-1:0]    next_q;

	logic                cur_valid;
	logic                addr_hit;
	logic                take;
	logic                finish;
	logic                wr_en;
	logic                clr_en;
	logic                flush_en;
	logic [SLOT_W-1:0]   wr_slot;

	logic [STATUS_W-1:0] r_status;
	logic [SLOT_W-1:0]   r_slot;
	logic [ADDR_W-1:0]   r_addr;
	logic [STATE_W-1:0]  r_state;
	logic [LQ_W-1:0]     r_lq;
	logic [IDX_W-1:0]    r_next;

	assign q_pop  = (state_fsm_q == ST_IDLE) && q_not_empty;
	assign finish = (state_fsm_q == ST_DONE) && (!out_valid_q || !out_stall);

	// per-slot compare during the walk
	assign cur_valid = valid_q[idx_q];
	assign addr_hit  = (addr_q[idx_q] == cmd_q.addr);

	always_comb begin
		case (cmd_q.kind)
			KIND_ADD, KIND_DEL: take = addr_hit;
			KIND_FINDA:         take = !found_q && cur_valid && addr_hit;
			KIND_FINDS:         take = !found_q && cur_valid && (state_q[idx_q] == cmd_q.state);
			KIND_ENUM:          take = !found_q && cur_valid &&
			                           (IDX_W'(idx_q) >= cmd_q.start);
			default:            take = 1'b0;
		endcase
	end

	// result and table update, resolved when the walk is done
	always_comb begin
		r_status = STATUS_OK;
		r_slot   = '0;
		r_addr   = '0;
		r_state  = '0;
		r_lq     = '0;
		r_next   = '0;
		wr_en    = 1'b0;
		clr_en   = 1'b0;
		flush_en = 1'b0;
		wr_slot  = hit_q;
		case (cmd_q.kind)
			KIND_ADD: begin
				wr_slot = found_q ? hit_q : free_q;
				if (found_q || free_found_q) begin
					wr_en   = 1'b1;
					r_slot  = wr_slot;
					r_addr  = cmd_q.addr;
					r_state = cmd_q.state;
					r_lq    = cmd_q.lq;
				end else begin
					r_status = STATUS_NO_FREE;
				end
			end
			KIND_DEL, KIND_FINDA, KIND_FINDS, KIND_ENUM: begin
				if (found_q) begin
					clr_en  = (cmd_q.kind == KIND_DEL);
					r_slot  = hit_q;
					r_addr  = cap_addr_q;
					r_state = cap_state_q;
					r_lq    = cap_lq_q;
					if (cmd_q.kind == KIND_ENUM) begin
						r_next = IDX_W'(hit_q) + IDX_W'(1);
					end
				end else begin
					r_status = STATUS_NOT_FOUND;
					if (cmd_q.kind == KIND_ENUM) begin
						r_next = cmd_q.start;
					end
				end
			end
			KIND_FLUSH: flush_en = 1'b1;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_fsm_q <= ST_IDLE;
		end else begin
			case (state_fsm_q)
				ST_IDLE: begin
					if (q_not_empty) begin
						if (q_head.kind == KIND_FLUSH || q_head.kind == KIND_NOP) begin
							state_fsm_q <= ST_DONE;
						end else begin
							state_fsm_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (idx_q == LAST_SLOT) begin
						state_fsm_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_fsm_q <= ST_IDLE;
					end
				end
				default: state_fsm_q <= ST_IDLE;
			endcase
		end
	end

	// walk bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (q_pop) begin
			idx_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (state_fsm_q == ST_WALK) begin
			idx_q <= idx_q + SLOT_W'(1);
			if (take) begin
				found_q <= 1'b1;
			end
			if (cmd_q.kind == KIND_ADD && !cur_valid) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// walk payload captures
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (state_fsm_q == ST_WALK) begin
			if (take) begin
				hit_q       <= idx_q;
				cap_addr_q  <= addr_q[idx_q];
				cap_state_q <= state_q[idx_q];
				cap_lq_q    <= lq_q[idx_q];
			end
			if (!cur_valid) begin
				free_q <= idx_q;
			end
		end
	end

	// table storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PEERS; i++) begin
				valid_q[i] <= 1'b0;
				addr_q[i]  <= '0;
				state_q[i] <= '0;
				lq_q[i]    <= LQ_CLEAR;
			end
		end else if (finish) begin
			if (flush_en) begin
				for (int i = 0; i < MAX_PEERS; i++) begin
					valid_q[i] <= 1'b0;
					addr_q[i]  <= '0;
					state_q[i] <= '0;
					lq_q[i]    <= LQ_CLEAR;
				end
			end else if (wr_en) begin
				valid_q[wr_slot] <= 1'b1;
				addr_q[wr_slot]  <= cmd_q.addr;
				state_q[wr_slot] <= cmd_q.state;
				lq_q[wr_slot]    <= cmd_q.lq;
			end else if (clr_en) begin
				valid_q[wr_slot] <= 1'b0;
				addr_q[wr_slot]  <= '0;
				state_q[wr_slot] <= '0;
				lq_q[wr_slot]    <= LQ_CLEAR;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q    <= r_status;
			slot_q      <= r_slot;
			res_addr_q  <= r_addr;
			res_state_q <= r_state;
			res_lq_q    <= r_lq;
			next_q      <= r_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign hit_slot         = slot_q;
	assign hit_address      = res_addr_q;
	assign hit_assoc_state  = res_state_q;
	assign hit_link_quality = res_lq_q;
	assign next_index       = next_q;

endmodule

FILE: sv/peer_address_table_top.sv
// ----------------------------------------------------------------------------
// peer_address_table_top
// Eight-slot associative peer table: add, delete, find by address or state,
// enumerate and flush, one result beat per command beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per beat: op,
//   peer_address, assoc_state_in, link_quality_in, start_index. Output
//   channel (out_valid / out_stall) returns one result beat per command, in
//   order: status, hit_slot, hit_address, hit_assoc_state, hit_link_quality,
//   next_index.
//   Table-walking ops pass through the queue, the pop, a walk over every
//   slot at one slot per cycle and the table update; flush and unused op
//   codes skip the walk. The back end takes the next command only after
//   the last result is loaded, so the slot walk sets the throughput.
//   A two-entry command queue lets the input side keep taking beats while
//   the back end walks; in_stall rises only when that queue is full.
//   When out_stall is high the result register holds; the back end waits
//   with its next result until the register is taken, and the queue fills.
//   Reset clears every slot (invalid, address 0, state 0, quality 255),
//   empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module peer_address_table_top import pat_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      op,
	input  logic [ADDR_W-1:0]    peer_address,
	input  logic [STATE_W-1:0]   assoc_state_in,
	input  logic [LQ_W-1:0]      link_quality_in,
	input  logic [IDX_W-1:0]     start_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_W-1:0]    hit_slot,
	output logic [ADDR_W-1:0]    hit_address,
	output logic [STATE_W-1:0]   hit_assoc_state,
	output logic [LQ_W-1:0]      hit_link_quality,
	output logic [IDX_W-1:0]     next_index
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_not_empty;
	cmd_t push_cmd;
	cmd_t head_cmd;

	// decode and accept
	pat_front u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.peer_address    (peer_address),
		.assoc_state_in  (assoc_state_in),
		.link_quality_in (link_quality_in),
		.start_index     (start_index),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_cmd           (push_cmd)
	);

	// command queue
	pat_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_cmd  (head_cmd)
	);

	// table and sequencer
	pat_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_not_empty      (q_not_empty),
		.q_head           (head_cmd),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.hit_slot         (hit_slot),
		.hit_address      (hit_address),
		.hit_assoc_state  (hit_assoc_state),
		.hit_link_quality (hit_link_quality),
		.next_index       (next_index)
	);

endmodule
